### sv/two_level_page_table_walker_macros.svh
// assertion macros for the two-level page table walker
// no dependencies; the assertions use the clock and reset names of the including module
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTH
`define TLPTW_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page table walker check failed");
`define TLPTW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page table walker check failed");
`else
`define TLPTW_ASSERT_IMPLY(name, ante, cons)
`define TLPTW_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### sv/tlptw_pkg.sv
// types and constants for the two-level page table walker
// no dependencies
package tlptw_pkg;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_DIR,
      WALK_TBL
   } walk_state_type;

   localparam logic [1:0] REQ_READ     = 2'd0;
   localparam logic [1:0] REQ_WRITE    = 2'd1;
   localparam logic [1:0] REQ_TABLE_WR = 2'd2;

   localparam logic REG_DIR_BASE = 1'b0;

   localparam int        PRESENT_BIT = 0;
   localparam logic [15:0] DIRTY_MASK = 16'h0002;

   localparam int ENTRY_W    = 16;
   localparam int FRAME_NUM_W = 12;
   localparam int PADDR_W    = 18;

endpackage

### sv/two_level_page_table_walker.sv
// Two-level page table walker:
// Requests come in on the req_ stream. req_tuser carries the request kind (read translate,
// write translate with dirty marking, table word write). Results leave on the rsp_ stream,
// one per request, from an output register: rsp_tuser is the fault flag and rsp_tdata the
// 18-bit physical byte address (zero on fault and for table writes).
// The csr_ port holds dir_base_frame at byte address 0; it must be written only while the
// walker is idle, and the block itself does not enforce this. A translation runs through
// accept and directory read, table read, then the dirty write back for write requests, as
// two dependent reads of the table memory; a missing directory entry ends after the directory
// read, and a table word write, an unused kind or a directory frame beyond the memory end
// at accept. The result is valid the cycle after the walk ends, and the next request is
// taken in that same cycle when the receiver takes the result.
// One request is in flight at a time, so the memory needs no forwarding.
// Reset clears the walk state, the output valid flag and dir_base_frame; the
// table memory is not cleared and must be written before it is read.
// When the receiver stalls, the result holds in the output register and req_tready stays low.
`include "two_level_page_table_walker_macros.svh"

module two_level_page_table_walker
   import tlptw_pkg::*;
#(
   parameter int FRAMES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // vaddr[15:0], word_index[32:16], word_data[48:33], zeros
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // paddr[17:0], zeros
   output logic        rsp_tuser,   // fault[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MEM_WORDS = FRAMES * 32;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int FRAME_W   = ADDR_W - 5;
   localparam logic [FRAME_NUM_W:0] FRAMES_LIM = (FRAME_NUM_W + 1)'(FRAMES);
   localparam logic [17:0]          WORDS_LIM  = 18'(MEM_WORDS);

   logic [ENTRY_W-1:0] mem [MEM_WORDS];

   walk_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic [PADDR_W-1:0]     rsp_paddr_ff, rsp_paddr_in;
   logic [FRAME_NUM_W-1:0] dir_base_ff, dir_base_in;
   logic [1:0]             req_type_ff, req_type_in;
   logic [15:0]            vaddr_ff, vaddr_in;
   logic [ADDR_W-1:0]      pt_addr_ff, pt_addr_in;
   logic [ENTRY_W-1:0]     rd_data_ff;

   logic [1:0]         in_type;
   logic [15:0]        in_vaddr;
   logic [16:0]        in_widx;
   logic [15:0]        in_wdata;
   logic               accept;
   logic               csr_write;
   logic               dir_inside;
   logic               widx_inside;
   logic               pt_inside;
   logic               pde_ok;
   logic               walk_start;
   logic               done;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;

   assign in_type  = req_tuser;
   assign in_vaddr = req_tdata[15:0];
   assign in_widx  = req_tdata[32:16];
   assign in_wdata = req_tdata[48:33];

   assign req_tready = (state_ff == WALK_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign dir_inside  = {1'b0, dir_base_ff} < FRAMES_LIM;
   assign widx_inside = {1'b0, in_widx} < WORDS_LIM;
   assign pt_inside   = {1'b0, rd_data_ff[15:4]} < FRAMES_LIM;
   assign pde_ok      = rd_data_ff[PRESENT_BIT] && pt_inside;
   assign walk_start  = accept && ((in_type == REQ_READ) || (in_type == REQ_WRITE)) &&
                        dir_inside;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_DIR_BASE);
   assign dir_base_in = csr_write ? csr_pwdata[FRAME_NUM_W-1:0] : dir_base_ff;
   assign csr_prdata  = (csr_paddr[2] == REG_DIR_BASE) ?
                        {{(32 - FRAME_NUM_W){1'b0}}, dir_base_ff} : 32'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WALK_IDLE: begin
            if (walk_start) begin
               state_in = WALK_DIR;
            end
         end
         WALK_DIR: begin
            state_in = pde_ok ? WALK_TBL : WALK_IDLE;
         end
         WALK_TBL: begin
            state_in = WALK_IDLE;
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   // memory accesses and result
   always_comb begin
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {dir_base_ff[FRAME_W-1:0], in_vaddr[15:11]};
      mem_wr_en    = 1'b0;
      mem_wr_addr  = in_widx[ADDR_W-1:0];
      mem_wr_data  = in_wdata;
      pt_addr_in   = pt_addr_ff;
      done         = 1'b0;
      rsp_fault_in = 1'b0;
      rsp_paddr_in = '0;
      case (state_ff)
         WALK_IDLE: begin
            if (accept) begin
               case (in_type)
                  REQ_READ, REQ_WRITE: begin
                     if (dir_inside) begin
                        mem_rd_en = 1'b1;
                     end else begin
                        done         = 1'b1;
                        rsp_fault_in = 1'b1;
                     end
                  end
                  REQ_TABLE_WR: begin
                     done      = 1'b1;
                     mem_wr_en = widx_inside;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         WALK_DIR: begin
            mem_rd_addr = {rd_data_ff[FRAME_W+3:4], vaddr_ff[10:6]};
            pt_addr_in  = mem_rd_addr;
            if (pde_ok) begin
               mem_rd_en = 1'b1;
            end else begin
               done         = 1'b1;
               rsp_fault_in = 1'b1;
            end
         end
         WALK_TBL: begin
            done        = 1'b1;
            mem_wr_addr = pt_addr_ff;
            mem_wr_data = rd_data_ff | DIRTY_MASK;
            if (!rd_data_ff[PRESENT_BIT]) begin
               rsp_fault_in = 1'b1;
            end else begin
               rsp_paddr_in = {rd_data_ff[15:4], vaddr_ff[5:0]};
               mem_wr_en    = (req_type_ff == REQ_WRITE);
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);
   assign req_type_in  = accept ? in_type : req_type_ff;
   assign vaddr_in     = accept ? in_vaddr : vaddr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         rsp_valid_ff <= 1'b0;
         dir_base_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_base_ff  <= dir_base_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      vaddr_ff    <= vaddr_in;
      pt_addr_ff  <= pt_addr_in;
      if (done) begin
         rsp_fault_ff <= rsp_fault_in;
         rsp_paddr_ff <= rsp_paddr_in;
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fault_ff;
   assign rsp_tdata  = {{(24 - PADDR_W){1'b0}}, rsp_paddr_ff};

   `TLPTW_ASSERT_NEXT(a_walk_starts, walk_start, state_ff == WALK_DIR)
   `TLPTW_ASSERT_IMPLY(a_busy_output_empty, state_ff != WALK_IDLE, !rsp_valid_ff)
   `TLPTW_ASSERT_IMPLY(a_writeback_on_write, mem_wr_en && (state_ff != WALK_IDLE),
      req_type_ff == REQ_WRITE)
   `TLPTW_ASSERT_IMPLY(a_fault_zero_addr, rsp_valid_ff && rsp_fault_ff, rsp_paddr_ff == '0)

endmodule
